@@ hw/rtl/trts_pkg.sv @@
// Package for the triangle ray transform setup: widths, payload structs and
// saturation constants. It depends on nothing and is used by every RTL file.
`default_nettype none
package trts_pkg;

   localparam int VTX_W  = 24;
   localparam int EDGE_W = VTX_W + 1;
   localparam int PRD_W  = 2 * EDGE_W;
   localparam int CPR_W  = 2 * VTX_W;
   localparam int NRM_W  = PRD_W + 1;
   localparam int CRS_W  = CPR_W + 1;
   localparam int NLO_W  = 25;
   localparam int NHI_W  = NRM_W - NLO_W;
   localparam int PPR_W  = VTX_W + NHI_W;
   localparam int NUM_SW = 76;
   localparam int NUM_W  = NUM_SW - 1;
   localparam int DEN_W  = NRM_W - 1;
   localparam int Q_W    = 32;
   localparam int CMP_W  = DEN_W + Q_W;
   localparam int LANES  = 9;
   localparam int EDGE_SH = 32;
   localparam int CRS_SH  = 16;
   localparam int NRM_SH  = 16;
   localparam int STAGES  = 7;

   localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic signed [VTX_W-1:0] a_x;
      logic signed [VTX_W-1:0] a_y;
      logic signed [VTX_W-1:0] a_z;
      logic signed [VTX_W-1:0] b_x;
      logic signed [VTX_W-1:0] b_y;
      logic signed [VTX_W-1:0] b_z;
      logic signed [VTX_W-1:0] c_x;
      logic signed [VTX_W-1:0] c_y;
      logic signed [VTX_W-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic [1:0]            pivot_axis;
      logic                  degenerate;
      logic                  overflow;
      logic signed [Q_W-1:0] r0_u;
      logic signed [Q_W-1:0] r0_v;
      logic signed [Q_W-1:0] r0_t;
      logic signed [Q_W-1:0] r1_u;
      logic signed [Q_W-1:0] r1_v;
      logic signed [Q_W-1:0] r1_t;
      logic signed [Q_W-1:0] r2_u;
      logic signed [Q_W-1:0] r2_v;
      logic signed [Q_W-1:0] r2_t;
   } rsp_type;

   typedef struct packed {
      logic                        valid;
      axis_type                    pivot;
      logic                        degen;
      logic [DEN_W-1:0]            den;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][NUM_W-1:0] num;
   } div_in_type;

   typedef struct packed {
      logic                      valid;
      axis_type                  pivot;
      logic                      degen;
      logic [LANES-1:0]          big;
      logic [LANES-1:0]          neg;
      logic [LANES-1:0][Q_W-1:0] q;
   } div_out_type;

endpackage
`default_nettype wire

@@ hw/rtl/trts_div.sv @@
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit per stage.
// It depends on trts_pkg for widths and the lane structs.
`default_nettype none
module trts_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  trts_pkg::div_in_type  din,
   output trts_pkg::div_out_type dout
);
   import trts_pkg::*;

   logic [Q_W:0]                v_ff;
   axis_type                    piv_ff  [0:Q_W];
   logic                        degen_ff[0:Q_W];
   logic [DEN_W-1:0]            den_ff  [0:Q_W];
   logic [LANES-1:0]            neg_ff  [0:Q_W];
   logic [LANES-1:0]            big_ff  [0:Q_W];
   logic [LANES-1:0][NUM_W-1:0] rem_ff  [0:Q_W];
   logic [LANES-1:0][Q_W-1:0]   q_ff    [0:Q_W];
   logic [LANES-1:0]            big_in;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         big_in[l] = CMP_W'(din.num[l]) >= {din.den, {Q_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Q_W-1:0], din.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         piv_ff[0]   <= din.pivot;
         degen_ff[0] <= din.degen;
         den_ff[0]   <= din.den;
         neg_ff[0]   <= din.neg;
         big_ff[0]   <= big_in;
         rem_ff[0]   <= din.num;
         q_ff[0]     <= '0;
      end
   end

   for (genvar s = 1; s <= Q_W; s++) begin : g_stage
      localparam int BIT = Q_W - s;
      logic [CMP_W-1:0]            trial;
      logic [LANES-1:0][NUM_W-1:0] rem_in;
      logic [LANES-1:0][Q_W-1:0]   q_in;

      assign trial = CMP_W'(den_ff[s-1]) << BIT;

      always_comb begin
         rem_in = rem_ff[s-1];
         q_in   = q_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            if (CMP_W'(rem_ff[s-1][l]) >= trial) begin
               rem_in[l]    = NUM_W'(CMP_W'(rem_ff[s-1][l]) - trial);
               q_in[l][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            piv_ff[s]   <= piv_ff[s-1];
            degen_ff[s] <= degen_ff[s-1];
            den_ff[s]   <= den_ff[s-1];
            neg_ff[s]   <= neg_ff[s-1];
            big_ff[s]   <= big_ff[s-1];
            rem_ff[s]   <= rem_in;
            q_ff[s]     <= q_in;
         end
      end
   end

   assign dout.valid = v_ff[Q_W];
   assign dout.pivot = piv_ff[Q_W];
   assign dout.degen = degen_ff[Q_W];
   assign dout.big   = big_ff[Q_W];
   assign dout.neg   = neg_ff[Q_W];
   assign dout.q     = q_ff[Q_W];

endmodule
`default_nettype wire

@@ hw/rtl/triangle_ray_transform_setup.sv @@
// Triangle ray transform setup: one transaction is accepted every cycle while rsp is not
// stalled. The pipeline ends in the 33-stage divider (range check plus one quotient bit
// per stage), followed by the registered result on rsp_valid.
// A stalled result holds the whole pipeline; synchronous reset clears all valid bits.
// Depends on trts_pkg and trts_div.
`default_nettype none
module triangle_ray_transform_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trts_pkg::rsp_type rsp_data
);
   import trts_pkg::*;

   logic adv;
   logic [STAGES:1] v_ff;

   logic signed [VTX_W-1:0]  va[0:2], vb[0:2], vc[0:2];
   logic signed [EDGE_W-1:0] e1_in[0:2], e2_in[0:2];

   logic signed [VTX_W-1:0]  a_s1_ff[0:2], b_s1_ff[0:2], c_s1_ff[0:2];
   logic signed [EDGE_W-1:0] e1_s1_ff[0:2], e2_s1_ff[0:2];

   logic signed [PRD_W-1:0]  np_s2_ff[0:5];
   logic signed [CPR_W-1:0]  ca_s2_ff[0:5], ba_s2_ff[0:5];
   logic signed [VTX_W-1:0]  a_s2_ff[0:2];
   logic signed [EDGE_W-1:0] e1_s2_ff[0:2], e2_s2_ff[0:2];

   logic signed [NRM_W-1:0]  n_s3_ff[0:2];
   logic signed [CRS_W-1:0]  ca_s3_ff[0:2], ba_s3_ff[0:2];
   logic signed [VTX_W-1:0]  a_s3_ff[0:2];
   logic signed [EDGE_W-1:0] e1_s3_ff[0:2], e2_s3_ff[0:2];

   axis_type                 piv_in;
   logic                     deg_in, swap;
   logic signed [EDGE_W-1:0] e1k1, e1k2, e2k1, e2k2;
   logic signed [NRM_W-1:0]  nk1, nk2, den_in;
   logic signed [CRS_W-1:0]  cx, bx;
   logic signed [NUM_SW-1:0] ra[0:2], rb[0:2], num_in[0:7];
   logic signed [PPR_W-1:0]  phi_in[0:2], plo_in[0:2];

   logic signed [NUM_SW-1:0] num_s4_ff[0:7];
   logic signed [NRM_W-1:0]  den_s4_ff;
   axis_type                 piv_s4_ff;
   logic                     deg_s4_ff;
   logic signed [PPR_W-1:0]  phi_s4_ff[0:2], plo_s4_ff[0:2];

   logic signed [NUM_SW-1:0] an_s5_ff[0:2];
   logic signed [NUM_SW-1:0] num_s5_ff[0:7];
   logic signed [NRM_W-1:0]  den_s5_ff;
   axis_type                 piv_s5_ff;
   logic                     deg_s5_ff;

   logic signed [NUM_SW-1:0] num_s6_ff[0:8];
   logic signed [NRM_W-1:0]  den_s6_ff;
   axis_type                 piv_s6_ff;
   logic                     deg_s6_ff;

   logic [LANES-1:0][NUM_W-1:0] mag_in;
   logic [LANES-1:0]            neg_in;
   logic signed [NUM_SW-1:0]    abs_tmp[0:8];
   logic signed [NRM_W-1:0]     dabs;
   logic [LANES-1:0][NUM_W-1:0] mag_s7_ff;
   logic [LANES-1:0]            neg_s7_ff;
   logic [DEN_W-1:0]            den_s7_ff;
   axis_type                    piv_s7_ff;
   logic                        deg_s7_ff;

   div_in_type  din;
   div_out_type dout;

   logic [Q_W-1:0] ent[0:8];
   logic           ovf_in;
   rsp_type        rsp_in, rsp_ff;
   logic           rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[STAGES-1:1], req_valid};
      end
   end

   always_comb begin
      va[0] = req_data.a_x; va[1] = req_data.a_y; va[2] = req_data.a_z;
      vb[0] = req_data.b_x; vb[1] = req_data.b_y; vb[2] = req_data.b_z;
      vc[0] = req_data.c_x; vc[1] = req_data.c_y; vc[2] = req_data.c_z;
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EDGE_W'(vb[i]) - EDGE_W'(va[i]);
         e2_in[i] = EDGE_W'(vc[i]) - EDGE_W'(va[i]);
      end
   end

   always_comb begin
      piv_in = AXIS_X;
      deg_in = 1'b0;
      if (n_s3_ff[0] != '0) begin
         piv_in = AXIS_X;
      end else if (n_s3_ff[1] != '0) begin
         piv_in = AXIS_Y;
      end else if (n_s3_ff[2] != '0) begin
         piv_in = AXIS_Z;
      end else begin
         deg_in = 1'b1;
      end
      case (piv_in)
         AXIS_Y: begin
            e1k1 = e1_s3_ff[2]; e1k2 = e1_s3_ff[0];
            e2k1 = e2_s3_ff[2]; e2k2 = e2_s3_ff[0];
            nk1 = n_s3_ff[2]; nk2 = n_s3_ff[0]; den_in = n_s3_ff[1];
            cx = ca_s3_ff[1]; bx = ba_s3_ff[1]; swap = 1'b1;
         end
         AXIS_Z: begin
            e1k1 = e1_s3_ff[0]; e1k2 = e1_s3_ff[1];
            e2k1 = e2_s3_ff[0]; e2k2 = e2_s3_ff[1];
            nk1 = n_s3_ff[0]; nk2 = n_s3_ff[1]; den_in = n_s3_ff[2];
            cx = ca_s3_ff[2]; bx = ba_s3_ff[2]; swap = 1'b0;
         end
         default: begin
            e1k1 = e1_s3_ff[1]; e1k2 = e1_s3_ff[2];
            e2k1 = e2_s3_ff[1]; e2k2 = e2_s3_ff[2];
            nk1 = n_s3_ff[1]; nk2 = n_s3_ff[2]; den_in = n_s3_ff[0];
            cx = ca_s3_ff[0]; bx = ba_s3_ff[0]; swap = 1'b0;
         end
      endcase
      ra[0] = NUM_SW'(e2k2) <<< EDGE_SH;
      rb[0] = (-NUM_SW'(e2k1)) <<< EDGE_SH;
      ra[1] = (-NUM_SW'(e1k2)) <<< EDGE_SH;
      rb[1] = NUM_SW'(e1k1) <<< EDGE_SH;
      ra[2] = NUM_SW'(nk1) <<< NRM_SH;
      rb[2] = NUM_SW'(nk2) <<< NRM_SH;
      for (int r = 0; r < 3; r++) begin
         num_in[3*r]   = swap ? rb[r] : ra[r];
         num_in[3*r+1] = swap ? ra[r] : rb[r];
      end
      num_in[2] = NUM_SW'(cx) <<< CRS_SH;
      num_in[5] = (-NUM_SW'(bx)) <<< CRS_SH;
      num_in[6] = swap ? rb[2] : ra[2];
      num_in[7] = swap ? ra[2] : rb[2];
      for (int i = 0; i < 3; i++) begin
         phi_in[i] = a_s3_ff[i] * $signed(n_s3_ff[i][NRM_W-1:NLO_W]);
         plo_in[i] = a_s3_ff[i] * $signed({1'b0, n_s3_ff[i][NLO_W-1:0]});
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         abs_tmp[l] = num_s6_ff[l][NUM_SW-1] ? -num_s6_ff[l] : num_s6_ff[l];
         mag_in[l]  = NUM_W'(abs_tmp[l]);
         neg_in[l]  = num_s6_ff[l][NUM_SW-1] ^ den_s6_ff[NRM_W-1];
      end
      dabs = den_s6_ff[NRM_W-1] ? -den_s6_ff : den_s6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a_s1_ff[i]  <= va[i];
            b_s1_ff[i]  <= vb[i];
            c_s1_ff[i]  <= vc[i];
            e1_s1_ff[i] <= e1_in[i];
            e2_s1_ff[i] <= e2_in[i];
         end

         np_s2_ff[0] <= e1_s1_ff[1] * e2_s1_ff[2];
         np_s2_ff[1] <= e1_s1_ff[2] * e2_s1_ff[1];
         np_s2_ff[2] <= e1_s1_ff[2] * e2_s1_ff[0];
         np_s2_ff[3] <= e1_s1_ff[0] * e2_s1_ff[2];
         np_s2_ff[4] <= e1_s1_ff[0] * e2_s1_ff[1];
         np_s2_ff[5] <= e1_s1_ff[1] * e2_s1_ff[0];
         ca_s2_ff[0] <= c_s1_ff[1] * a_s1_ff[2];
         ca_s2_ff[1] <= c_s1_ff[2] * a_s1_ff[1];
         ca_s2_ff[2] <= c_s1_ff[2] * a_s1_ff[0];
         ca_s2_ff[3] <= c_s1_ff[0] * a_s1_ff[2];
         ca_s2_ff[4] <= c_s1_ff[0] * a_s1_ff[1];
         ca_s2_ff[5] <= c_s1_ff[1] * a_s1_ff[0];
         ba_s2_ff[0] <= b_s1_ff[1] * a_s1_ff[2];
         ba_s2_ff[1] <= b_s1_ff[2] * a_s1_ff[1];
         ba_s2_ff[2] <= b_s1_ff[2] * a_s1_ff[0];
         ba_s2_ff[3] <= b_s1_ff[0] * a_s1_ff[2];
         ba_s2_ff[4] <= b_s1_ff[0] * a_s1_ff[1];
         ba_s2_ff[5] <= b_s1_ff[1] * a_s1_ff[0];
         for (int i = 0; i < 3; i++) begin
            a_s2_ff[i]  <= a_s1_ff[i];
            e1_s2_ff[i] <= e1_s1_ff[i];
            e2_s2_ff[i] <= e2_s1_ff[i];
         end

         for (int i = 0; i < 3; i++) begin
            n_s3_ff[i]  <= NRM_W'(np_s2_ff[2*i]) - NRM_W'(np_s2_ff[2*i+1]);
            ca_s3_ff[i] <= CRS_W'(ca_s2_ff[2*i]) - CRS_W'(ca_s2_ff[2*i+1]);
            ba_s3_ff[i] <= CRS_W'(ba_s2_ff[2*i]) - CRS_W'(ba_s2_ff[2*i+1]);
            a_s3_ff[i]  <= a_s2_ff[i];
            e1_s3_ff[i] <= e1_s2_ff[i];
            e2_s3_ff[i] <= e2_s2_ff[i];
         end

         for (int k = 0; k < 8; k++) begin
            num_s4_ff[k] <= num_in[k];
         end
         for (int i = 0; i < 3; i++) begin
            phi_s4_ff[i] <= phi_in[i];
            plo_s4_ff[i] <= plo_in[i];
         end
         den_s4_ff <= den_in;
         piv_s4_ff <= piv_in;
         deg_s4_ff <= deg_in;

         for (int i = 0; i < 3; i++) begin
            an_s5_ff[i] <= (NUM_SW'(phi_s4_ff[i]) <<< NLO_W) + NUM_SW'(plo_s4_ff[i]);
         end
         for (int k = 0; k < 8; k++) begin
            num_s5_ff[k] <= num_s4_ff[k];
         end
         den_s5_ff <= den_s4_ff;
         piv_s5_ff <= piv_s4_ff;
         deg_s5_ff <= deg_s4_ff;

         for (int k = 0; k < 8; k++) begin
            num_s6_ff[k] <= num_s5_ff[k];
         end
         num_s6_ff[8] <= -(an_s5_ff[0] + an_s5_ff[1] + an_s5_ff[2]);
         den_s6_ff    <= den_s5_ff;
         piv_s6_ff    <= piv_s5_ff;
         deg_s6_ff    <= deg_s5_ff;

         mag_s7_ff <= mag_in;
         neg_s7_ff <= neg_in;
         den_s7_ff <= DEN_W'(dabs);
         piv_s7_ff <= piv_s6_ff;
         deg_s7_ff <= deg_s6_ff;
      end
   end

   assign din.valid = v_ff[STAGES];
   assign din.pivot = piv_s7_ff;
   assign din.degen = deg_s7_ff;
   assign din.den   = den_s7_ff;
   assign din.neg   = neg_s7_ff;
   assign din.num   = mag_s7_ff;

   trts_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .din   (din),
      .dout  (dout)
   );

   always_comb begin
      ovf_in = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         if (dout.neg[l]) begin
            if (dout.big[l] || dout.q[l] > SAT_NEG) begin
               ent[l] = SAT_NEG;
               ovf_in = 1'b1;
            end else begin
               ent[l] = -dout.q[l];
            end
         end else begin
            if (dout.big[l] || dout.q[l] > SAT_POS) begin
               ent[l] = SAT_POS;
               ovf_in = 1'b1;
            end else begin
               ent[l] = dout.q[l];
            end
         end
      end
      if (dout.degen) begin
         rsp_in = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.pivot_axis = dout.pivot;
         rsp_in.degenerate = 1'b0;
         rsp_in.overflow   = ovf_in;
         rsp_in.r0_u = ent[0];
         rsp_in.r0_v = ent[1];
         rsp_in.r0_t = ent[2];
         rsp_in.r1_u = ent[3];
         rsp_in.r1_v = ent[4];
         rsp_in.r1_t = ent[5];
         rsp_in.r2_u = ent[6];
         rsp_in.r2_v = ent[7];
         rsp_in.r2_t = ent[8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dout.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.degenerate |->
         rsp_ff.pivot_axis == AXIS_X && !rsp_ff.overflow && rsp_ff.r0_u == '0 &&
         rsp_ff.r2_t == '0)
      else $error("degenerate transaction carries nonzero fields");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(dout))
      else $error("divider pipeline moved while the result was stalled");

   a_div_to_rsp: assert property (@(posedge clock) disable iff (reset)
      adv && dout.valid |=> rsp_valid_ff)
      else $error("divider result was not captured by the output register");
`endif

endmodule
`default_nettype wire
